/* rtl/dctf_pkg.sv */
package dctf_pkg;

  localparam int POINTS          = 8;
  localparam int SAMPLE_BITS     = 9;
  localparam int BASIS_FRAC_BITS = 14;

  localparam int COEF_W        = 11;
  localparam int COEF_MAX      = 1023;
  localparam int COEF_MIN_MAG  = 1024;
  localparam int HALF_PERIOD_Q = 30;

  // Enables for the two lane pipeline stages.
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } pipe_ctrl_t;

  // 0.5*cos(pi*m/16) for m = 0..8 in Q.30.
  localparam longint HALF_COS_Q30 [POINTS+1] = '{
    64'd536870912, 64'd526555088, 64'd496004047, 64'd446391849, 64'd379625062,
    64'd298269498, 64'd205451603, 64'd104738319, 64'd0
  };

  // sqrt(1/8) in Q.30.
  localparam longint DC_SCALE_Q30 = 64'd379625062;

  // Signed basis entry for coefficient k and sample n with frac fraction bits.
  function automatic int basis_coef(input int k, input int n, input int frac);
    int     m;
    int     sh;
    bit     neg;
    longint mag;
    sh  = HALF_PERIOD_Q - frac;
    neg = 1'b0;
    if (k == 0) begin
      mag = DC_SCALE_Q30;
    end else begin
      m = ((2 * n + 1) * k) % (4 * POINTS);
      if (m > 2 * POINTS) begin
        m = 4 * POINTS - m;
      end
      if (m > POINTS) begin
        m   = 2 * POINTS - m;
        neg = 1'b1;
      end
      mag = HALF_COS_Q30[m];
    end
    mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    return neg ? -int'(mag) : int'(mag);
  endfunction

endpackage

/* rtl/dctf_lane.sv */
module dctf_lane #(
  parameter int SampleBits = dctf_pkg::SAMPLE_BITS,
  parameter int FracBits   = dctf_pkg::BASIS_FRAC_BITS,
  parameter int Lane       = 0
) (
  input  logic                                          clk_i,
  input  dctf_pkg::pipe_ctrl_t                          ctrl_i,
  input  logic [dctf_pkg::POINTS-1:0][SampleBits-1:0]   samples_i,
  output logic [dctf_pkg::COEF_W-1:0]                   coef_o
);

  localparam int BasisW = FracBits + 1;
  localparam int ProdW  = SampleBits + FracBits;
  localparam int SumW   = ProdW + 3;
  localparam int MagW   = SumW + 1;
  localparam int RndW   = MagW - FracBits;

  localparam logic [RndW-1:0] MaxPos = RndW'(dctf_pkg::COEF_MAX);
  localparam logic [RndW-1:0] MaxNeg = RndW'(dctf_pkg::COEF_MIN_MAG);
  localparam logic [MagW-1:0] Half   = MagW'(1) << (FracBits - 1);

  logic signed [ProdW-1:0] prod_d [dctf_pkg::POINTS];
  logic signed [ProdW-1:0] prod_q [dctf_pkg::POINTS];
  logic signed [SumW-1:0]  sum_d;
  logic signed [SumW-1:0]  sum_q;

  for (genvar n = 0; n < dctf_pkg::POINTS; n++) begin : g_tap
    localparam int Coef = dctf_pkg::basis_coef(Lane, n, FracBits);
    logic signed [BasisW-1:0]     basis;
    logic signed [SampleBits-1:0] sample;
    assign basis     = BasisW'(Coef);
    assign sample    = $signed(samples_i[n]);
    assign prod_d[n] = sample * basis;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int n = 0; n < dctf_pkg::POINTS; n++) begin
      sum_d = sum_d + SumW'(prod_q[n]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_q <= sum_d;
    end
  end

  // Round the magnitude half away from zero, then restore the sign and clamp.
  logic                          neg;
  logic [MagW-1:0]               mag;
  logic [MagW-1:0]               rnd;
  logic [RndW-1:0]               rmag;
  logic [dctf_pkg::COEF_W-1:0]   rtrunc;

  always_comb begin
    neg    = sum_q[SumW-1];
    mag    = neg ? MagW'(-MagW'(sum_q)) : MagW'(sum_q);
    rnd    = mag + Half;
    rmag   = rnd[MagW-1:FracBits];
    rtrunc = rmag[dctf_pkg::COEF_W-1:0];
    if (!neg && rmag > MaxPos) begin
      coef_o = MaxPos[dctf_pkg::COEF_W-1:0];
    end else if (neg && rmag > MaxNeg) begin
      coef_o = MaxNeg[dctf_pkg::COEF_W-1:0];
    end else begin
      coef_o = neg ? -rtrunc : rtrunc;
    end
  end

endmodule

/* rtl/dctf_merge.sv */
module dctf_merge #(
  parameter int OutW = dctf_pkg::POINTS * dctf_pkg::COEF_W
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               valid_i,
  output logic                                               ready_o,
  input  logic [dctf_pkg::POINTS-1:0][dctf_pkg::COEF_W-1:0]  coefs_i,
  output logic                                               valid_o,
  input  logic                                               ready_i,
  output logic [OutW-1:0]                                    data_o
);

  logic            valid_q;
  logic            valid_d;
  logic [OutW-1:0] data_q;

  // The output register takes a new row when empty or when its row leaves.
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= OutW'(coefs_i);
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/dct2_8point_forward.sv */
// Eight-point forward DCT-II, one row of samples per transfer.
// The result passes through the multiply, sum and output registers in that order.
// Throughput: one row per cycle; the multiply, sum and output registers each
// stall only when the stage after them is full and not draining.
// Reset clears the stage valid flags; data registers are not reset.
module dct2_8point_forward #(
  parameter int SampleBits = dctf_pkg::SAMPLE_BITS,
  parameter int FracBits   = dctf_pkg::BASIS_FRAC_BITS,
  localparam int InW  = ((dctf_pkg::POINTS * SampleBits + 7) / 8) * 8,
  localparam int OutW = ((dctf_pkg::POINTS * dctf_pkg::COEF_W + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // sample_0 .. sample_7, SampleBits each, sample_0 lowest, zero padded
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // coef_0 .. coef_7, 11 bits each, coef_0 lowest, zero padded
  output logic [OutW-1:0] m_axis_tdata
);

  logic mul_vld_q;
  logic sum_vld_q;
  logic mul_en;
  logic sum_en;
  logic out_rdy;

  dctf_pkg::pipe_ctrl_t ctrl;
  logic [dctf_pkg::POINTS-1:0][SampleBits-1:0]       samples;
  logic [dctf_pkg::POINTS-1:0][dctf_pkg::COEF_W-1:0] coefs;

  assign sum_en        = !sum_vld_q || out_rdy;
  assign mul_en        = !mul_vld_q || sum_en;
  assign s_axis_tready = mul_en;
  assign ctrl.mul_en   = mul_en;
  assign ctrl.sum_en   = sum_en;
  assign samples       = s_axis_tdata[dctf_pkg::POINTS*SampleBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      if (mul_en) begin
        mul_vld_q <= s_axis_tvalid;
      end
      if (sum_en) begin
        sum_vld_q <= mul_vld_q;
      end
    end
  end

  for (genvar k = 0; k < dctf_pkg::POINTS; k++) begin : g_lane
    dctf_lane #(
      .SampleBits(SampleBits),
      .FracBits  (FracBits),
      .Lane      (k)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .samples_i(samples),
      .coef_o   (coefs[k])
    );
  end

  dctf_merge #(
    .OutW(OutW)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(sum_vld_q),
    .ready_o(out_rdy),
    .coefs_i(coefs),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (m_axis_tdata)
  );

  // An empty output register never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  // Without backpressure a transferred row passes the sum stage and reaches the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid)
    else $error("row lost in pipeline");

  // A result appears only when the sum stage held a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(sum_vld_q))
    else $error("output valid without a summed row");

endmodule
